FILE: rtl/crsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsp_pkg
// Shared constants and types for the Catmull-Rom segment sampler.
// ----------------------------------------------------------------------------
package crsp_pkg;

   localparam int COORD_BITS_DEF = 16;    // Q8.8 coordinates
   localparam int T_BITS         = 16;    // Q0.16 curve parameter
   localparam int COEF_GUARD     = 4;     // growth of the cubic coefficients
   localparam int ACC_GUARD      = 24;    // growth of the Horner accumulator

   localparam logic [T_BITS-1:0] T_STEP_RESET = 16'd1638;  // about 0.025
   localparam logic [T_BITS-1:0] T_STEP_MIN   = 16'd1024;  // caps a segment at 64 words

   // control from the sequencer to the shared multiply-round-add unit
   typedef struct packed {
      logic enable;     // load the product register
      logic seed_sel;   // multiply the fresh seed instead of the running sum
   } mac_ctl_type;

endpackage

FILE: rtl/crsp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsp_mac
// Shared Horner step: prod = x * t registered, then rnd(prod / 2^16) + k * 2^16.
// ----------------------------------------------------------------------------
module crsp_mac #(
   parameter int COORD_BITS = crsp_pkg::COORD_BITS_DEF
) (
   input  logic                                                      clock,
   input  crsp_pkg::mac_ctl_type                                     ctl,
   input  logic signed [COORD_BITS+crsp_pkg::ACC_GUARD-1:0]          seed,
   input  logic signed [COORD_BITS+crsp_pkg::COEF_GUARD-1:0]         coef,
   input  logic        [crsp_pkg::T_BITS-1:0]                        t_value,
   output logic signed [COORD_BITS+crsp_pkg::ACC_GUARD-1:0]          acc
);

   localparam int KW = COORD_BITS + crsp_pkg::COEF_GUARD;
   localparam int HW = COORD_BITS + crsp_pkg::ACC_GUARD;
   localparam int PW = HW + crsp_pkg::T_BITS + 1;
   localparam int TB = crsp_pkg::T_BITS;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_rnd;
   logic signed [HW-1:0] mul_op;
   logic signed [HW-1:0] coef_shift;

   // round half up, drop the 16 fraction bits, add the next coefficient
   assign prod_rnd   = prod_ff + PW'(1 << (TB - 1));
   assign coef_shift = {{(HW-KW-TB){coef[KW-1]}}, coef, {TB{1'b0}}};
   assign acc        = prod_rnd[HW+TB-1:TB] + coef_shift;

   assign mul_op  = ctl.seed_sel ? seed : acc;
   assign prod_in = mul_op * $signed({1'b0, t_value});

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         prod_ff <= prod_in;
      end
   end

endmodule

FILE: rtl/catmull_rom_segment_points.sv
`timescale 1ns / 1ps
// Per sample word the sequencer steps through AX, BX, CX, AY, BY, CY and DY
//   (three multiplies per axis on one shared multiplier, then the output step,
//   which holds while a result word waits); ceil(65536 / step) words per
//   segment. Points, stored ones included, are taken only in the idle state, so
//   no point is taken while a segment is being sampled.
// Reset (synchronous): clears the held point count, restores t_increment to
//   1638 and drops any pending result word.
// ----------------------------------------------------------------------------
// catmull_rom_segment_points
// Uniform Catmull-Rom segment sampler: keeps three control points and, for
// each further point, walks t over [0,1) evaluating the cubic in Horner form.
// ----------------------------------------------------------------------------
module catmull_rom_segment_points #(
   parameter int COORD_BITS = crsp_pkg::COORD_BITS_DEF,
   localparam int TDW = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // control points
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [TDW-1:0]               req_tdata,   // point_x, point_y, zero pad
   input  logic                         req_tuser,   // start_curve
   // curve samples
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [TDW-1:0]               rsp_tdata,   // curve_x, curve_y, zero pad
   output logic                         rsp_tlast,   // segment_last
   // t_increment register
   input  logic                         csr_wr_en,
   input  logic [crsp_pkg::T_BITS-1:0]  csr_wr_data
);

   localparam int W  = COORD_BITS;
   localparam int TB = crsp_pkg::T_BITS;
   localparam int KW = W + crsp_pkg::COEF_GUARD;
   localparam int HW = W + crsp_pkg::ACC_GUARD;
   localparam int RW = HW - TB - 1;
   localparam logic signed [RW-1:0] R_MAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [RW-1:0] R_MIN = ~R_MAX;

   // sequencer: AX/AY seed a*t, BX..CY fold in b and c, AY/DY finish x/y
   typedef enum logic [7:0] {
      PH_IDLE = 8'b0000_0001,
      PH_AX   = 8'b0000_0010,
      PH_BX   = 8'b0000_0100,
      PH_CX   = 8'b0000_1000,
      PH_AY   = 8'b0001_0000,
      PH_BY   = 8'b0010_0000,
      PH_CY   = 8'b0100_0000,
      PH_DY   = 8'b1000_0000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [1:0]             held_ff, held_in;
   logic [TB-1:0]          tinc_ff;
   logic [TB-1:0]          step_ff;
   logic [TB-1:0]          t_ff, t_in;
   logic signed [W-1:0]    hist_ff [2][3];
   logic signed [KW-1:0]   coef_a_ff [2], coef_b_ff [2], coef_c_ff [2], coef_d_ff [2];
   logic signed [KW-1:0]   coef_a_in [2], coef_b_in [2], coef_c_in [2], coef_d_in [2];
   logic signed [W-1:0]    res_x_ff;
   logic                   rsp_tvalid_ff;
   logic [TDW-1:0]         rsp_tdata_ff;
   logic                   rsp_tlast_ff;

   logic                   req_take;
   logic                   seg_start;
   logic                   out_free;
   logic                   out_load;
   logic [TB:0]            t_next;
   logic                   t_last;
   logic signed [W-1:0]    point [2];

   crsp_pkg::mac_ctl_type  mac_ctl;
   logic signed [HW-1:0]   mac_seed;
   logic signed [KW-1:0]   mac_coef;
   logic signed [HW-1:0]   mac_acc;
   logic signed [HW-1:0]   fin_sum;
   logic signed [RW-1:0]   fin_r;
   logic signed [W-1:0]    fin_sat;

   assign point[0] = $signed(req_tdata[W-1:0]);
   assign point[1] = $signed(req_tdata[2*W-1:W]);

   assign req_tready = (phase_ff == PH_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign seg_start  = req_take && !req_tuser && (held_ff == 2'd3);

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign out_load = (phase_ff == PH_DY) && out_free;

   // segment ends when the next t would reach 1.0
   assign t_next = {1'b0, t_ff} + {1'b0, step_ff};
   assign t_last = t_next[TB];

   // cubic coefficients; the new point is P3, the history P0..P2
   always_comb begin
      logic signed [KW-1:0] e0, e1, e2, e3;
      for (int ax = 0; ax < 2; ax++) begin
         e0 = KW'(hist_ff[ax][0]);
         e1 = KW'(hist_ff[ax][1]);
         e2 = KW'(hist_ff[ax][2]);
         e3 = KW'(point[ax]);
         coef_a_in[ax] = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
         coef_b_in[ax] = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
         coef_c_in[ax] = e2 - e0;
         coef_d_in[ax] = e1 <<< 1;
      end
   end

   // shared unit operand selection; the product is frozen in the output
   // step so a stalled y result stays put
   always_comb begin
      mac_ctl.enable   = (phase_ff != PH_IDLE) && (phase_ff != PH_DY);
      mac_ctl.seed_sel = (phase_ff == PH_AX) || (phase_ff == PH_AY);
      mac_seed = (phase_ff == PH_AY)
               ? {{(HW-KW-TB){coef_a_ff[1][KW-1]}}, coef_a_ff[1], {TB{1'b0}}}
               : {{(HW-KW-TB){coef_a_ff[0][KW-1]}}, coef_a_ff[0], {TB{1'b0}}};
      case (phase_ff)
         PH_BX:   mac_coef = coef_b_ff[0];
         PH_CX:   mac_coef = coef_c_ff[0];
         PH_AY:   mac_coef = coef_d_ff[0];
         PH_BY:   mac_coef = coef_b_ff[1];
         PH_CY:   mac_coef = coef_c_ff[1];
         PH_DY:   mac_coef = coef_d_ff[1];
         default: mac_coef = '0;
      endcase
   end

   crsp_mac #(
      .COORD_BITS (COORD_BITS)
   ) u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .seed    (mac_seed),
      .coef    (mac_coef),
      .t_value (t_ff),
      .acc     (mac_acc)
   );

   // final factor 0.5 with round half up, then clamp to the coordinate range
   assign fin_sum = mac_acc + HW'(1 << TB);
   assign fin_r   = fin_sum[HW-1:TB+1];
   always_comb begin
      if (fin_r > R_MAX) begin
         fin_sat = R_MAX[W-1:0];
      end else if (fin_r < R_MIN) begin
         fin_sat = R_MIN[W-1:0];
      end else begin
         fin_sat = fin_r[W-1:0];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      t_in     = t_ff;
      held_in  = held_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (req_take) begin
               if (req_tuser) begin
                  held_in = 2'd1;
               end else if (held_ff != 2'd3) begin
                  held_in = held_ff + 2'd1;
               end
               if (seg_start) begin
                  phase_in = PH_AX;
                  t_in     = '0;
               end
            end
         end
         PH_AX:   phase_in = PH_BX;
         PH_BX:   phase_in = PH_CX;
         PH_CX:   phase_in = PH_AY;
         PH_AY:   phase_in = PH_BY;
         PH_BY:   phase_in = PH_CY;
         PH_CY:   phase_in = PH_DY;
         PH_DY: begin
            if (out_free) begin
               phase_in = t_last ? PH_IDLE : PH_AX;
               t_in     = t_next[TB-1:0];
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         held_ff       <= '0;
         tinc_ff       <= crsp_pkg::T_STEP_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         if (csr_wr_en) begin
            tinc_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      t_ff <= t_in;
      if (req_take) begin
         for (int ax = 0; ax < 2; ax++) begin
            if (req_tuser) begin
               hist_ff[ax][0] <= point[ax];
            end else if (held_ff == 2'd3) begin
               hist_ff[ax][0] <= hist_ff[ax][1];
               hist_ff[ax][1] <= hist_ff[ax][2];
               hist_ff[ax][2] <= point[ax];
            end else begin
               hist_ff[ax][held_ff] <= point[ax];
            end
         end
      end
      if (seg_start) begin
         step_ff <= (tinc_ff < crsp_pkg::T_STEP_MIN) ? crsp_pkg::T_STEP_MIN : tinc_ff;
         for (int ax = 0; ax < 2; ax++) begin
            coef_a_ff[ax] <= coef_a_in[ax];
            coef_b_ff[ax] <= coef_b_in[ax];
            coef_c_ff[ax] <= coef_c_in[ax];
            coef_d_ff[ax] <= coef_d_in[ax];
         end
      end
      if (phase_ff == PH_AY) begin
         res_x_ff <= fin_sat;
      end
      if (out_load) begin
         rsp_tdata_ff <= TDW'({fin_sat, res_x_ff});
         rsp_tlast_ff <= t_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // a waiting word blocks the sequencer in its output step
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DY && !out_free) |=> (phase_ff == PH_DY))
      else $error("sequencer left output step while result word was held");

   // a non-final word means more samples of the segment are still in work
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (phase_ff != PH_IDLE))
      else $error("segment ended without a final word");

   // a fourth point of a curve starts a segment walk
   a_seg_start: assert property (@(posedge clock) disable iff (reset)
      seg_start |=> (phase_ff == PH_AX && t_ff == '0))
      else $error("segment did not start at t = 0");

   // nothing is accepted while a segment is being sampled
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> !req_tready)
      else $error("point accepted during segment sampling");

endmodule

FILE: test/catmull_rom_segment_points_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_segment_points_test
// Self-checking bench for the Catmull-Rom segment sampler. A queue of control
// points feeds a clocked driver. Each point the block takes is run through a
// local fixed-point model of the segment cubic, and the model's sample words
// are queued. A clocked monitor compares every sample word the block emits,
// field by field, with the oldest queued word. Both sides idle in random
// bursts. The step register is swept between phases, extremes included.
// ----------------------------------------------------------------------------
module catmull_rom_segment_points_test;

   localparam int  CLK_HALF     = 10;        // 20 ns period
   localparam int  DRAIN_CYCLES = 16;        // covers the first-word latency
   localparam int  T_ONE        = 65536;     // 1.0 in Q0.16
   localparam longint SAT_MAX   = 32767;
   localparam longint SAT_MIN   = -32768;

   // one control point as it travels on the request side
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               start;
   } ctrl_point_type;

   // one predicted sample word
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } curve_sample_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // point_x, point_y
   logic        req_tuser   = 1'b0; // start_curve
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // curve_x, curve_y
   logic        rsp_tlast;          // segment_last
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   ctrl_point_type   pending_points[$];     // points not yet offered
   curve_sample_type expected_samples[$];   // sample words still to come
   ctrl_point_type   active_point;          // point on the request bus

   // local copy of the block's state
   logic [15:0] step_setting = crsp_pkg::T_STEP_RESET;
   longint      hist_x[3];
   longint      hist_y[3];
   int          held_count = 0;

   bit idling_on  = 1'b1;
   int send_gap   = 0;
   int stall_left = 0;
   int fail_count = 0;

   catmull_rom_segment_points u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // rnd(v * t / 2^16): split v so the low part's product stays non-negative
   function automatic longint scale_by_t(input longint v, input longint t);
      longint lo;
      longint hi;
      lo = v & 64'hFFFF;
      hi = v >>> 16;
      return hi * t + ((lo * t + 32768) >>> 16);
   endfunction

   // one axis of the segment at parameter t, Horner form, rounded and saturated
   function automatic logic [15:0] eval_axis_sample(input longint p0, input longint p1,
                                                    input longint p2, input longint p3,
                                                    input longint t);
      longint a, b, c, d, h1, h2, h3, r;
      a  = -p0 + 3 * p1 - 3 * p2 + p3;
      b  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c  = p2 - p0;
      d  = 2 * p1;
      h1 = a * t + b * 65536;
      h2 = scale_by_t(h1, t) + c * 65536;
      h3 = scale_by_t(h2, t) + d * 65536;
      r  = (h3 + 65536) >>> 17;   // the extra shift bit is the 0.5 factor
      if (r > SAT_MAX) r = SAT_MAX;
      if (r < SAT_MIN) r = SAT_MIN;
      return r[15:0];
   endfunction

   // advance the local state by one taken point and queue its sample words
   task automatic predict_segment_samples(input ctrl_point_type pt);
      longint           px;
      longint           py;
      int unsigned      step;
      int unsigned      t;
      curve_sample_type s;
      px = longint'(pt.x);
      py = longint'(pt.y);
      if (pt.start) begin
         // new curve: drop the history, this point becomes the only one held
         held_count = 0;
      end else if (held_count == 3) begin
         step = 32'((step_setting < crsp_pkg::T_STEP_MIN) ? crsp_pkg::T_STEP_MIN
                                                          : step_setting);
         for (t = 0; t < T_ONE; t += step) begin
            s.x    = eval_axis_sample(hist_x[0], hist_x[1], hist_x[2], px, longint'(t));
            s.y    = eval_axis_sample(hist_y[0], hist_y[1], hist_y[2], py, longint'(t));
            s.last = (t + step >= T_ONE);
            expected_samples.push_back(s);
         end
      end
      if (held_count < 3) begin
         hist_x[held_count] = px;
         hist_y[held_count] = py;
         held_count++;
      end else begin
         hist_x[0] = hist_x[1];
         hist_x[1] = hist_x[2];
         hist_x[2] = px;
         hist_y[0] = hist_y[1];
         hist_y[1] = hist_y[2];
         hist_y[2] = py;
      end
   endtask

   // Request driver. A point is predicted at the edge where it is taken,
   // then the next one (or a gap) is put on the bus.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) predict_segment_samples(active_point);
         if (!req_tvalid || req_tready) begin
            if (idling_on && send_gap != 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_points.size() != 0) begin
               active_point = pending_points.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {active_point.y, active_point.x};
               req_tuser  <= active_point.start;
               // occasional idle burst before the following word
               if (idling_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      curve_sample_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected sample word: curve_x %0d curve_y %0d segment_last %0b",
                      $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]), rsp_tlast);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[15:0] !== want.x) begin
                  $error("curve_x: expected %0d, actual %0d",
                         $signed(want.x), $signed(rsp_tdata[15:0]));
                  fail_count++;
               end
               if (rsp_tdata[31:16] !== want.y) begin
                  $error("curve_y: expected %0d, actual %0d",
                         $signed(want.y), $signed(rsp_tdata[31:16]));
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("segment_last: expected %0b, actual %0b", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (idling_on && stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 17);
         end
      end
   end

   task automatic queue_point(input logic [15:0] x, input logic [15:0] y, input logic start);
      ctrl_point_type pt;
      pt.x     = x;
      pt.y     = y;
      pt.start = start;
      pending_points.push_back(pt);
   endtask

   // mostly moderate values, with full-range noise and the rails mixed in
   function automatic logic [15:0] random_coord();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0:       v = 16'h7FFF;
         1:       v = 16'h8000;
         2, 3:    v = 16'($urandom);
         default: v = 16'($urandom_range(0, 8191) - 4096);
      endcase
      return v;
   endfunction

   // Runs of points that open with a start flag, so most of them reach the
   // segment stage; a stray start mid-run or a missing opener adds noise.
   task automatic queue_random_points(input int count);
      int left;
      int run;
      left = count;
      while (left > 0) begin
         run = $urandom_range(3, 10);
         queue_point(random_coord(), random_coord(), $urandom_range(0, 9) != 0);
         left--;
         for (int k = 0; k < run && left > 0; k++) begin
            queue_point(random_coord(), random_coord(), $urandom_range(0, 19) == 0);
            left--;
         end
      end
   endtask

   // everything offered, taken and checked, plus a margin for stored points;
   // the state is sampled at the falling edge, after the driver has settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_points.size() != 0 || req_tvalid || expected_samples.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // must be called right after a rising edge, with the block idle
   task automatic write_step(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      step_setting = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset step. The first three points after reset
      // are only stored; the fourth opens the first segment.
      queue_point(16'h7FFF, 16'h8000, 1'b0);
      queue_point(16'h8000, 16'h7FFF, 1'b0);
      queue_point(16'h7FFF, 16'h7FFF, 1'b0);
      queue_point(16'h8000, 16'h8000, 1'b0);   // wild swing, saturates
      queue_point(16'h0000, 16'h0000, 1'b0);
      queue_point(16'h0100, 16'hFF00, 1'b0);
      // new curve on a full history, then again with only two points held
      queue_point(16'd100, 16'd200, 1'b1);
      queue_point(16'd300, -16'sd400, 1'b0);
      queue_point(-16'sd500, 16'd600, 1'b1);
      queue_point(16'h0100, 16'h0200, 1'b0);
      queue_point(16'h0300, 16'h0400, 1'b0);
      queue_point(16'h0500, 16'h0600, 1'b0);   // P1, P2 and P3 on one line
      queue_point(16'hFFFF, 16'h0001, 1'b0);
      // flat curve: four copies of one point
      queue_point(16'h1234, 16'hEDCC, 1'b1);
      queue_point(16'h1234, 16'hEDCC, 1'b0);
      queue_point(16'h1234, 16'hEDCC, 1'b0);
      queue_point(16'h1234, 16'hEDCC, 1'b0);
      // alternating patterns toggle every data bit
      queue_point(16'h5555, 16'hAAAA, 1'b0);
      queue_point(16'hAAAA, 16'h5555, 1'b0);
      wait_idle();

      // two samples per segment
      write_step(16'hFFFF);
      queue_random_points(30);
      wait_idle();

      // zero and just below the floor both act as the minimum step
      write_step(16'h0000);
      queue_random_points(10);
      wait_idle();
      write_step(crsp_pkg::T_STEP_MIN);
      queue_random_points(8);
      wait_idle();
      write_step(crsp_pkg::T_STEP_MIN - 16'd1);
      queue_random_points(8);
      wait_idle();

      // mostly coarse steps keep the run short
      repeat (5) begin
         write_step(16'($urandom_range(2048, 65535)));
         queue_random_points(25);
         wait_idle();
      end

      // closing stretch at full rate, no idling on either side
      idling_on = 1'b0;
      write_step(crsp_pkg::T_STEP_RESET);
      queue_random_points(20);
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog: several times the slowest legal run
   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
